// ----- design/tld_pkg.sv -----
// Shared types and constants for the terminal line discipline.
// Holds the event codes, the special characters and the result beat layout.
// No dependencies.
package tld_pkg;

  // Event codes carried in the op field of an input beat.
  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_TX_DONE = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;

  // One result beat.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       write_accepted;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_newline;
  } result_t;

endpackage

// ----- design/tld_in_if.sv -----
// Input event channel of the terminal line discipline.
// Carries valid, ready and the event fields. No dependencies.
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] terminal;
  logic [7:0] data;

  modport source (output valid, output op, output terminal, output data, input ready);
  modport sink   (input valid, input op, input terminal, input data, output ready);
endinterface

// ----- design/tld_out_if.sv -----
// Result channel of the terminal line discipline.
// Carries valid, ready and the result fields. No dependencies.
interface tld_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_char;
  logic       write_accepted;
  logic       read_valid;
  logic [7:0] read_char;
  logic       read_newline;

  modport source (output valid, output tx_valid, output tx_char, output write_accepted,
                  output read_valid, output read_char, output read_newline, input ready);
  modport sink   (input valid, input tx_valid, input tx_char, input write_accepted,
                  input read_valid, input read_char, input read_newline, output ready);
endinterface

// ----- design/tld_ram.sv -----
// Byte-wide single-port-write, single-port-read memory with registered read data.
// Used for the input and echo queues. No dependencies.
module tld_ram #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tld_step.sv -----
// Per-event logic of the terminal line discipline: one terminal's queue context
// and the bytes read from its queues go in, the result and the new context come out.
// Depends on tld_pkg.
module tld_step #(
  parameter  int INPUT_DEPTH = 256,
  parameter  int ECHO_DEPTH  = 256,
  localparam int IPW = $clog2(INPUT_DEPTH),
  localparam int ICW = $clog2(INPUT_DEPTH + 1),
  localparam int EPW = $clog2(ECHO_DEPTH),
  localparam int ECW = $clog2(ECHO_DEPTH + 1)
) (
  input  tld_pkg::op_t             op,
  input  logic                     term_ok,
  input  logic [7:0]               data,
  input  logic [IPW-1:0]           ih,
  input  logic [IPW-1:0]           it,
  input  logic [ICW-1:0]           ic,
  input  logic [EPW-1:0]           eh,
  input  logic [EPW-1:0]           et,
  input  logic [ECW-1:0]           ec,
  input  logic                     busy,
  input  logic [7:0]               in_rd,
  input  logic [7:0]               ec_rd,
  output logic [IPW-1:0]           ih_n,
  output logic [IPW-1:0]           it_n,
  output logic [ICW-1:0]           ic_n,
  output logic [EPW-1:0]           eh_n,
  output logic [EPW-1:0]           et_n,
  output logic [ECW-1:0]           ec_n,
  output logic                     busy_n,
  output tld_pkg::result_t         res,
  output logic                     in_we,
  output logic [7:0]               in_wchar,
  output logic [1:0]               push_cnt,
  output logic [2:0][7:0]          push_char,
  output logic [2:0][EPW-1:0]      push_ptr
);
  import tld_pkg::*;

  function automatic logic [IPW-1:0] in_inc(input logic [IPW-1:0] p);
    return (p == IPW'(INPUT_DEPTH - 1)) ? '0 : p + IPW'(1);
  endfunction

  function automatic logic [IPW-1:0] in_dec(input logic [IPW-1:0] p);
    return (p == '0) ? IPW'(INPUT_DEPTH - 1) : p - IPW'(1);
  endfunction

  function automatic logic [EPW-1:0] ec_inc(input logic [EPW-1:0] p);
    return (p == EPW'(ECHO_DEPTH - 1)) ? '0 : p + EPW'(1);
  endfunction

  logic [7:0]      ch;
  logic            blocked;
  logic [1:0]      want;
  logic [2:0][7:0] list;
  logic [ECW-1:0]  room;
  logic [1:0]      k;
  logic [EPW-1:0]  p1, p2, p3;

  always_comb begin
    ih_n     = ih;
    it_n     = it;
    ic_n     = ic;
    eh_n     = eh;
    ec_n     = ec;
    busy_n   = busy;
    res      = '0;
    in_we    = 1'b0;
    want     = 2'd0;
    list     = '0;
    blocked  = 1'b0;
    ch       = (data == CH_CR) ? CH_LF : data;
    in_wchar = ch;

    if (term_ok) begin
      case (op)
        OP_RECEIVE: begin
          if (ch inside {CH_BS, CH_DEL}) begin
            // An erase never reaches back past the end of a finished line.
            blocked = (ic != '0) && (in_rd == CH_LF);
            if ((ic != '0) && !blocked) begin
              it_n = in_dec(it);
              ic_n = ic - ICW'(1);
            end
            if (!blocked) begin
              if (busy) begin
                want = 2'd3;
                list = {CH_BS, CH_SP, CH_BS};
              end else begin
                res.tx_valid = 1'b1;
                res.tx_char  = CH_BS;
                busy_n       = 1'b1;
                want         = 2'd2;
                list         = {8'h00, CH_BS, CH_SP};
              end
            end
          end else if (ic < ICW'(INPUT_DEPTH)) begin
            in_we = 1'b1;
            it_n  = in_inc(it);
            ic_n  = ic + ICW'(1);
            if (ch == CH_LF) begin
              if (busy) begin
                want = 2'd2;
                list = {8'h00, CH_LF, CH_CR};
              end else begin
                res.tx_valid = 1'b1;
                res.tx_char  = CH_CR;
                busy_n       = 1'b1;
                want         = 2'd1;
                list         = {16'h0000, CH_LF};
              end
            end else if (busy) begin
              want = 2'd1;
              list = {16'h0000, ch};
            end else begin
              res.tx_valid = 1'b1;
              res.tx_char  = ch;
              busy_n       = 1'b1;
            end
          end
        end
        OP_TX_DONE: begin
          busy_n = 1'b0;
          if (ec != '0) begin
            res.tx_valid = 1'b1;
            res.tx_char  = ec_rd;
            eh_n         = ec_inc(eh);
            ec_n         = ec - ECW'(1);
            busy_n       = 1'b1;
          end
        end
        OP_WRITE: begin
          if (!busy) begin
            res.tx_valid = 1'b1;
            busy_n       = 1'b1;
            if (ec != '0) begin
              res.tx_char = ec_rd;
              eh_n        = ec_inc(eh);
              ec_n        = ec - ECW'(1);
            end else begin
              res.write_accepted = 1'b1;
              if (data == CH_LF) begin
                res.tx_char = CH_CR;
                want        = 2'd1;
                list        = {16'h0000, CH_LF};
              end else begin
                res.tx_char = data;
              end
            end
          end
        end
        OP_READ: begin
          if (ic != '0) begin
            res.read_valid   = 1'b1;
            res.read_char    = in_rd;
            res.read_newline = (in_rd == CH_LF);
            ih_n             = in_inc(ih);
            ic_n             = ic - ICW'(1);
          end
        end
        default: ;
      endcase
    end

    // Echo bytes that do not fit are dropped one by one.
    room = ECW'(ECHO_DEPTH) - ec;
    k    = (room < ECW'(want)) ? room[1:0] : want;
    p1   = ec_inc(et);
    p2   = ec_inc(p1);
    p3   = ec_inc(p2);
    if (want != 2'd0) begin
      ec_n = ec + ECW'(k);
    end
    case (k)
      2'd0:    et_n = et;
      2'd1:    et_n = p1;
      2'd2:    et_n = p2;
      default: et_n = p3;
    endcase
    push_cnt  = k;
    push_char = list;
    push_ptr  = {p2, p1, et};
  end

endmodule

// ----- design/terminal_line_discipline_core.sv -----
// Top level of the terminal line discipline: per-terminal queue pointers, the
// input and echo queue memories, the event stage and the result register.
// Depends on tld_pkg, tld_in_if, tld_out_if, tld_ram and tld_step.
//
//   channel  | dir | beat contents                                   | accepted when
//   ---------+-----+-------------------------------------------------+----------------------
//   item     | in  | op, terminal, data                              | item.valid & ready
//   result   | out | tx_valid, tx_char, write_accepted, read_valid,  | result.valid & ready
//            |     | read_char, read_newline                         |
//
// Flow: an input beat is taken into the event stage, processed there, and its result
// beat is written to the result register when the event stage completes.
// One beat per cycle is sustained while result.ready stays high. An event that
// queues two or three echo bytes holds item.ready low until the extra bytes are
// written, because the echo memory has a single write port and writes one byte
// per cycle.
// Reset (rst, synchronous) clears the pointers, counts and busy flags of every
// terminal and empties the pipeline; the queue memories are not cleared.
// Stalls: while result.ready is low the result register holds its beat and one
// further event can still be taken and wait in the event stage.
module terminal_line_discipline_core #(
  parameter int TERMINALS   = 4,
  parameter int INPUT_DEPTH = 256,
  parameter int ECHO_DEPTH  = 256
) (
  input  logic      clk,
  input  logic      rst,
  tld_in_if.sink    item,
  tld_out_if.source result
);
  import tld_pkg::*;

  localparam int TW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int IPW = $clog2(INPUT_DEPTH);
  localparam int ICW = $clog2(INPUT_DEPTH + 1);
  localparam int EPW = $clog2(ECHO_DEPTH);
  localparam int ECW = $clog2(ECHO_DEPTH + 1);
  localparam int IAW = TW + IPW;
  localparam int EAW = TW + EPW;

  // Per-terminal queue state. Each array is read at the incoming event's terminal
  // and written back at the terminal of the event that completes.
  logic [IPW-1:0]       in_head  [TERMINALS];
  logic [IPW-1:0]       in_tail  [TERMINALS];
  logic [ICW-1:0]       in_count [TERMINALS];
  logic [EPW-1:0]       echo_head  [TERMINALS];
  logic [EPW-1:0]       echo_tail  [TERMINALS];
  logic [ECW-1:0]       echo_count [TERMINALS];
  logic [TERMINALS-1:0] tx_busy;

  // Event stage: the event and a private copy of its terminal's context.
  logic           s1_valid;
  op_t            s1_op;
  logic [TW-1:0]  s1_term;
  logic           s1_tok;
  logic [7:0]     s1_data;
  logic [IPW-1:0] c_ih, c_it;
  logic [ICW-1:0] c_ic;
  logic [EPW-1:0] c_eh, c_et;
  logic [ECW-1:0] c_ec;
  logic           c_busy;

  // Read data bypass for a memory write that lands at the edge of the read.
  logic           in_byp_hit;
  logic [7:0]     in_byp_data;
  logic           ec_byp_hit;
  logic [7:0]     ec_byp_data;
  logic [7:0]     in_q, ec_q;
  logic [7:0]     in_rd, ec_rd;

  // Result register.
  logic           out_valid;
  result_t        out_res;

  // Echo bytes still to be written after the event that queued them.
  logic [1:0]           pend_cnt;
  logic [1:0]           pend_cnt_next;
  logic [TW-1:0]        pend_term;
  logic [1:0][EPW-1:0]  pend_ptr;
  logic [1:0][7:0]      pend_char;

  // Step outputs.
  logic [IPW-1:0]       n_ih, n_it;
  logic [ICW-1:0]       n_ic;
  logic [EPW-1:0]       n_eh, n_et;
  logic [ECW-1:0]       n_ec;
  logic                 n_busy;
  result_t              step_res;
  logic                 step_in_we;
  logic [7:0]           step_in_wchar;
  logic [1:0]           push_cnt;
  logic [2:0][7:0]      push_char;
  logic [2:0][EPW-1:0]  push_ptr;

  // Incoming event view.
  logic           s1_fire, in_fire;
  logic [TW-1:0]  in_term;
  logic           in_tok;
  logic           fwd;
  logic [IPW-1:0] y_ih, y_it, y_last;
  logic [ICW-1:0] y_ic;
  logic [EPW-1:0] y_eh, y_et;
  logic [ECW-1:0] y_ec;
  logic           y_busy;

  // Memory ports.
  logic           in_we, in_re;
  logic [IAW-1:0] in_waddr, in_raddr;
  logic           ec_we, ec_re;
  logic [EAW-1:0] ec_waddr, ec_raddr;
  logic [7:0]     ec_wdata;

  assign in_rd = in_byp_hit ? in_byp_data : in_q;
  assign ec_rd = ec_byp_hit ? ec_byp_data : ec_q;

  tld_step #(
    .INPUT_DEPTH (INPUT_DEPTH),
    .ECHO_DEPTH  (ECHO_DEPTH)
  ) u_step (
    .op        (s1_op),
    .term_ok   (s1_tok),
    .data      (s1_data),
    .ih        (c_ih),
    .it        (c_it),
    .ic        (c_ic),
    .eh        (c_eh),
    .et        (c_et),
    .ec        (c_ec),
    .busy      (c_busy),
    .in_rd     (in_rd),
    .ec_rd     (ec_rd),
    .ih_n      (n_ih),
    .it_n      (n_it),
    .ic_n      (n_ic),
    .eh_n      (n_eh),
    .et_n      (n_et),
    .ec_n      (n_ec),
    .busy_n    (n_busy),
    .res       (step_res),
    .in_we     (step_in_we),
    .in_wchar  (step_in_wchar),
    .push_cnt  (push_cnt),
    .push_char (push_char),
    .push_ptr  (push_ptr)
  );

  // The event stage completes when the result register is free or being emptied.
  assign s1_fire = s1_valid && (!out_valid || result.ready);

  // Extra echo bytes of a completing event are drained one per cycle afterwards.
  always_comb begin
    if (s1_fire) begin
      pend_cnt_next = (push_cnt == 2'd0) ? 2'd0 : push_cnt - 2'd1;
    end else if (pend_cnt != 2'd0) begin
      pend_cnt_next = pend_cnt - 2'd1;
    end else begin
      pend_cnt_next = 2'd0;
    end
  end

  // A new event is taken only when every earlier echo write is done by the same
  // edge, so its memory reads see all older queue contents.
  assign item.ready = (!s1_valid || s1_fire) && (pend_cnt_next == 2'd0);
  assign in_fire    = item.valid && item.ready;

  assign in_term = TW'(item.terminal);
  assign in_tok  = 32'(item.terminal) < TERMINALS;

  // When the completing event belongs to the same terminal, the new event takes
  // its updated context instead of the stored one.
  assign fwd    = s1_fire && s1_tok && (s1_term == in_term);
  assign y_ih   = fwd ? n_ih   : in_head[in_term];
  assign y_it   = fwd ? n_it   : in_tail[in_term];
  assign y_ic   = fwd ? n_ic   : in_count[in_term];
  assign y_eh   = fwd ? n_eh   : echo_head[in_term];
  assign y_et   = fwd ? n_et   : echo_tail[in_term];
  assign y_ec   = fwd ? n_ec   : echo_count[in_term];
  assign y_busy = fwd ? n_busy : tx_busy[in_term];
  assign y_last = (y_it == '0) ? IPW'(INPUT_DEPTH - 1) : y_it - IPW'(1);

  // Input queue: a read takes the head, an erase looks at the last queued byte.
  assign in_re    = in_fire && in_tok;
  assign in_raddr = {in_term, (op_t'(item.op) == OP_READ) ? y_ih : y_last};
  assign in_we    = s1_fire && step_in_we;
  assign in_waddr = {s1_term, c_it};

  // Echo queue: the completing event writes its first echo byte, later bytes
  // follow from the pending slots.
  assign ec_re    = in_fire && in_tok;
  assign ec_raddr = {in_term, y_eh};
  always_comb begin
    if (pend_cnt != 2'd0) begin
      ec_we    = 1'b1;
      ec_waddr = {pend_term, pend_ptr[0]};
      ec_wdata = pend_char[0];
    end else begin
      ec_we    = s1_fire && (push_cnt != 2'd0);
      ec_waddr = {s1_term, push_ptr[0]};
      ec_wdata = push_char[0];
    end
  end

  tld_ram #(.AW(IAW)) u_input_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (step_in_wchar),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_q)
  );

  tld_ram #(.AW(EAW)) u_echo_ram (
    .clk   (clk),
    .we    (ec_we),
    .waddr (ec_waddr),
    .wdata (ec_wdata),
    .re    (ec_re),
    .raddr (ec_raddr),
    .rdata (ec_q)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pend_cnt  <= 2'd0;
      tx_busy   <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        in_head[i]    <= '0;
        in_tail[i]    <= '0;
        in_count[i]   <= '0;
        echo_head[i]  <= '0;
        echo_tail[i]  <= '0;
        echo_count[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      pend_cnt <= pend_cnt_next;
      if (s1_fire && s1_tok) begin
        in_head[s1_term]    <= n_ih;
        in_tail[s1_term]    <= n_it;
        in_count[s1_term]   <= n_ic;
        echo_head[s1_term]  <= n_eh;
        echo_tail[s1_term]  <= n_et;
        echo_count[s1_term] <= n_ec;
        tx_busy[s1_term]    <= n_busy;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op       <= op_t'(item.op);
      s1_term     <= in_term;
      s1_tok      <= in_tok;
      s1_data     <= item.data;
      c_ih        <= y_ih;
      c_it        <= y_it;
      c_ic        <= y_ic;
      c_eh        <= y_eh;
      c_et        <= y_et;
      c_ec        <= y_ec;
      c_busy      <= y_busy;
      in_byp_hit  <= in_we && (in_waddr == in_raddr);
      in_byp_data <= step_in_wchar;
      ec_byp_hit  <= ec_we && (ec_waddr == ec_raddr);
      ec_byp_data <= ec_wdata;
    end
    if (s1_fire) begin
      out_res      <= step_res;
      pend_term    <= s1_term;
      pend_ptr[0]  <= push_ptr[1];
      pend_ptr[1]  <= push_ptr[2];
      pend_char[0] <= push_char[1];
      pend_char[1] <= push_char[2];
    end else if (pend_cnt != 2'd0) begin
      pend_ptr[0]  <= pend_ptr[1];
      pend_char[0] <= pend_char[1];
    end
  end

  assign result.valid          = out_valid;
  assign result.tx_valid       = out_res.tx_valid;
  assign result.tx_char        = out_res.tx_char;
  assign result.write_accepted = out_res.write_accepted;
  assign result.read_valid     = out_res.read_valid;
  assign result.read_char      = out_res.read_char;
  assign result.read_newline   = out_res.read_newline;

endmodule

// ----- design/tld_checker.sv -----
// Port-level checks for the terminal line discipline, and the bind that
// attaches them to terminal_line_discipline_core. Depends on tld_pkg.
module tld_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       tx_valid,
  input logic [7:0] tx_char,
  input logic       write_accepted,
  input logic       read_valid,
  input logic [7:0] read_char,
  input logic       read_newline
);
  import tld_pkg::*;

  // A result beat that is not taken stays and keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({tx_valid, tx_char, write_accepted, read_valid, read_char, read_newline}))
    else $error("result beat changed while stalled");

  // Every accepted event is followed by a valid result beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> ##1 res_valid)
    else $error("no result beat after an accepted event");

  // An accepted user write always sends its byte or its translation.
  a_write: assert property (@(posedge clk) disable iff (rst)
    res_valid && write_accepted |-> tx_valid && !read_valid)
    else $error("write accepted without a transmitted byte");

  // The newline flag only comes with a read that returned LF.
  a_newline: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_newline |-> read_valid && (read_char == CH_LF))
    else $error("newline flag without a line feed read");

endmodule

bind terminal_line_discipline_core tld_checker u_tld_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .tx_valid       (result.tx_valid),
  .tx_char        (result.tx_char),
  .write_accepted (result.write_accepted),
  .read_valid     (result.read_valid),
  .read_char      (result.read_char),
  .read_newline   (result.read_newline)
);

// ----- bench/terminal_line_discipline_core_checker.sv -----
// Result checker for the terminal line discipline: watches both channels, predicts
// each result beat from the accepted event beats and compares them in order.
// Depends on tld_pkg, tld_in_if and tld_out_if.
`timescale 1ns / 1ps

module terminal_line_discipline_core_checker #(
  parameter int TERMINALS   = 4,
  parameter int INPUT_DEPTH = 256,
  parameter int ECHO_DEPTH  = 256
) (
  input  logic clk,
  input  logic rst,
  tld_in_if    item,
  tld_out_if   result,
  output int   fail_count,
  output int   outstanding
);
  import tld_pkg::*;

  // Per-terminal shadow of the input queue, the echo queue and the busy flag.
  logic [7:0]  line_mem [TERMINALS][INPUT_DEPTH];
  int unsigned line_rd [TERMINALS];
  int unsigned line_wr [TERMINALS];
  int unsigned line_fill [TERMINALS];
  logic [7:0]  echo_mem [TERMINALS][ECHO_DEPTH];
  int unsigned echo_rd [TERMINALS];
  int unsigned echo_wr [TERMINALS];
  int unsigned echo_fill [TERMINALS];
  bit          tx_busy [TERMINALS];

  result_t owed_results [$];
  result_t got;
  result_t want;

  function automatic void echo_push(int unsigned t, logic [7:0] c);
    if (echo_fill[t] >= ECHO_DEPTH) return;
    echo_mem[t][echo_wr[t]] = c;
    echo_wr[t] = (echo_wr[t] + 1 >= ECHO_DEPTH) ? 0 : echo_wr[t] + 1;
    echo_fill[t]++;
  endfunction

  function automatic logic [7:0] echo_pop(int unsigned t);
    logic [7:0] c;
    c = echo_mem[t][echo_rd[t]];
    echo_rd[t] = (echo_rd[t] + 1 >= ECHO_DEPTH) ? 0 : echo_rd[t] + 1;
    echo_fill[t]--;
    return c;
  endfunction

  // Send right away when the transmitter is idle, otherwise park the byte as echo.
  function automatic bit send_or_echo(int unsigned t, logic [7:0] c, output logic [7:0] txc);
    txc = 8'h00;
    if (tx_busy[t]) begin
      echo_push(t, c);
      return 1'b0;
    end
    txc = c;
    tx_busy[t] = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t discipline_step(logic [1:0] op_bits, int unsigned t,
                                              logic [7:0] data);
    result_t     r;
    op_t         op;
    logic [7:0]  ch;
    logic [7:0]  txc;
    int unsigned last;
    bit          erase_ok;
    r = '0;
    op = op_t'(op_bits);
    ch = data;
    txc = 8'h00;
    if (t < TERMINALS) begin
      case (op)
        OP_RECEIVE: begin
          if (ch == CH_CR) ch = CH_LF;
          if (ch == CH_BS || ch == CH_DEL) begin
            erase_ok = 1'b1;
            if (line_fill[t] > 0) begin
              last = (line_wr[t] == 0) ? INPUT_DEPTH - 1 : line_wr[t] - 1;
              // A completed line can no longer be edited.
              if (line_mem[t][last] == CH_LF) begin
                erase_ok = 1'b0;
              end else begin
                line_wr[t] = last;
                line_fill[t]--;
              end
            end
            if (erase_ok) begin
              r.tx_valid = send_or_echo(t, CH_BS, txc);
              echo_push(t, CH_SP);
              echo_push(t, CH_BS);
            end
          end else if (line_fill[t] < INPUT_DEPTH) begin
            line_mem[t][line_wr[t]] = ch;
            line_wr[t] = (line_wr[t] + 1 >= INPUT_DEPTH) ? 0 : line_wr[t] + 1;
            line_fill[t]++;
            if (ch == CH_LF) begin
              r.tx_valid = send_or_echo(t, CH_CR, txc);
              echo_push(t, CH_LF);
            end else begin
              r.tx_valid = send_or_echo(t, ch, txc);
            end
          end
        end
        OP_TX_DONE: begin
          tx_busy[t] = 1'b0;
          if (echo_fill[t] > 0) begin
            txc = echo_pop(t);
            r.tx_valid = 1'b1;
            tx_busy[t] = 1'b1;
          end
        end
        OP_WRITE: begin
          if (!tx_busy[t]) begin
            if (echo_fill[t] > 0) begin
              txc = echo_pop(t);
            end else begin
              r.write_accepted = 1'b1;
              if (ch == CH_LF) begin
                txc = CH_CR;
                echo_push(t, CH_LF);
              end else begin
                txc = ch;
              end
            end
            r.tx_valid = 1'b1;
            tx_busy[t] = 1'b1;
          end
        end
        default: begin
          if (line_fill[t] > 0) begin
            r.read_char = line_mem[t][line_rd[t]];
            line_rd[t] = (line_rd[t] + 1 >= INPUT_DEPTH) ? 0 : line_rd[t] + 1;
            line_fill[t]--;
            r.read_valid = 1'b1;
            r.read_newline = (r.read_char == CH_LF);
          end
        end
      endcase
    end
    r.tx_char = r.tx_valid ? txc : 8'h00;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TERMINALS; i++) begin
        line_rd[i] = 0;
        line_wr[i] = 0;
        line_fill[i] = 0;
        echo_rd[i] = 0;
        echo_wr[i] = 0;
        echo_fill[i] = 0;
        tx_busy[i] = 1'b0;
      end
      owed_results.delete();
      fail_count <= 0;
    end else begin
      if (item.valid && item.ready)
        owed_results.push_back(discipline_step(item.op, item.terminal, item.data));
      if (result.valid && result.ready) begin
        got = '{tx_valid: result.tx_valid, tx_char: result.tx_char,
                write_accepted: result.write_accepted, read_valid: result.read_valid,
                read_char: result.read_char, read_newline: result.read_newline};
        if (owed_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing expected: tx %b/%h wacc %b rd %b/%h/%b",
                     $realtime, got.tx_valid, got.tx_char, got.write_accepted,
                     got.read_valid, got.read_char, got.read_newline);
          fail_count <= fail_count + 1;
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch: expected tx %b/%h wacc %b rd %b/%h/%b",
                       $realtime, want.tx_valid, want.tx_char, want.write_accepted,
                       want.read_valid, want.read_char, want.read_newline);
              $display("%0t:                  got      tx %b/%h wacc %b rd %b/%h/%b",
                       $realtime, got.tx_valid, got.tx_char, got.write_accepted,
                       got.read_valid, got.read_char, got.read_newline);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

// ----- bench/terminal_line_discipline_core_tb.sv -----
// Top of the terminal line discipline testbench: clock, reset, event stimulus,
// result back-pressure and the verdict.
// Depends on tld_pkg, tld_in_if, tld_out_if, the core and its checker.
`timescale 1ns / 1ps

module terminal_line_discipline_core_tb;
  import tld_pkg::*;

  localparam int TERMINALS   = 4;
  localparam int INPUT_DEPTH = 256;
  localparam int ECHO_DEPTH  = 256;
  // Well above the slowest legal run: about 1050 beats, each of which may wait
  // out long sender gaps, a receiver that stalls more than half the time and
  // the extra cycles an erase takes to write its three echo bytes.
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   home_term;

  tld_in_if  item_ch ();
  tld_out_if result_ch ();

  terminal_line_discipline_core #(
    .TERMINALS  (TERMINALS),
    .INPUT_DEPTH(INPUT_DEPTH),
    .ECHO_DEPTH (ECHO_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  terminal_line_discipline_core_checker #(
    .TERMINALS  (TERMINALS),
    .INPUT_DEPTH(INPUT_DEPTH),
    .ECHO_DEPTH (ECHO_DEPTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side: ready drops at random according to the current phase.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog. A run that is still going at the limit has hung or lost results.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("** terminal_line_discipline_core: FAILED **");
    $finish;
  end

  // Present one event beat and hold it until the core takes it. Idle cycles go
  // in front of the beat, so valid only ever drops between beats. Each time step
  // sees at most one assignment to valid.
  task automatic post_event(op_t op, int term, logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.op       <= op;
    item_ch.terminal <= term[1:0];
    item_ch.data     <= data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Received characters lean on the ones the discipline treats specially (carriage
  // return, line feed and the two erase codes) and on NUL.
  function automatic logic [7:0] pick_rx_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_CR;
    if (r < 17) return CH_LF;
    if (r < 23) return CH_BS;
    if (r < 28) return CH_DEL;
    if (r < 31) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // A mix of typing, transmitter completions, reads and writes. Most events go
  // to one home terminal so that lines build up and queues get deep; the home
  // terminal moves now and then. When pinned is not negative every event goes
  // to that terminal.
  task automatic random_events(int count, int rx_pct, int pinned);
    int   term;
    int   r;
    op_t  op;
    logic [7:0] data;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) home_term = $urandom_range(0, TERMINALS - 1);
      term = home_term;
      if ($urandom_range(0, 99) < 15) term = $urandom_range(0, TERMINALS - 1);
      if (pinned >= 0) term = pinned;
      data = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < rx_pct) begin
        op = OP_RECEIVE;
        data = pick_rx_char();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          op = OP_TX_DONE;
        end else if (r < 75) begin
          op = OP_READ;
        end else begin
          op = OP_WRITE;
          if ($urandom_range(0, 5) == 0) data = CH_LF;
        end
      end
      post_event(op, term, data);
    end
  endtask

  // Fill one terminal without ever completing a transmission or reading, so
  // both its input queue and its echo queue run full and start dropping.
  task automatic flood_terminal(int term);
    logic [7:0] data;
    for (int n = 0; n < INPUT_DEPTH + 6; n++) begin
      data = pick_rx_char();
      if (data == CH_BS || data == CH_DEL) data = 8'h41 + n[4:0];
      post_event(OP_RECEIVE, term, data);
    end
    // Erasing on a full queue, then refilling the freed slots.
    post_event(OP_RECEIVE, term, CH_DEL);
    post_event(OP_RECEIVE, term, CH_BS);
    post_event(OP_RECEIVE, term, CH_DEL);
    post_event(OP_RECEIVE, term, 8'h5A);
    post_event(OP_RECEIVE, term, 8'hA5);
  endtask

  initial begin
    int flood_term;
    rst              <= 1'b1;
    item_ch.valid    <= 1'b0;
    item_ch.op       <= OP_RECEIVE;
    item_ch.terminal <= 2'd0;
    item_ch.data     <= 8'h00;
    home_term = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed beats, no idling. The sequence starts on an empty, idle terminal
    // and then walks through the corner cases one by one.
    post_event(OP_READ, 0, 8'hFF);        // read with nothing queued
    post_event(OP_TX_DONE, 0, 8'h00);     // completion with no echo waiting
    post_event(OP_RECEIVE, 0, CH_BS);     // erase on an empty line still echoes
    post_event(OP_WRITE, 0, 8'h41);       // refused, transmitter busy
    post_event(OP_TX_DONE, 0, 8'h00);     // space goes out
    post_event(OP_TX_DONE, 0, 8'h00);     // backspace goes out
    post_event(OP_TX_DONE, 0, 8'h00);     // back to idle
    post_event(OP_RECEIVE, 0, 8'h00);     // NUL is an ordinary character
    post_event(OP_RECEIVE, 0, 8'hFF);     // queued as echo behind the NUL
    post_event(OP_WRITE, 0, 8'hFF);       // refused while busy
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_RECEIVE, 0, CH_CR);     // becomes LF, echoed as CR then LF
    post_event(OP_RECEIVE, 0, CH_DEL);    // erase after a line feed does nothing
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_WRITE, 0, CH_LF);       // accepted, CR now and LF as echo
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_TX_DONE, 0, 8'h00);
    post_event(OP_READ, 0, 8'h00);        // NUL
    post_event(OP_READ, 0, 8'h00);        // 0xFF
    post_event(OP_READ, 0, 8'h00);        // LF ends the line
    post_event(OP_READ, 0, 8'h00);        // empty again
    post_event(OP_RECEIVE, 3, 8'h80);
    post_event(OP_WRITE, 3, 8'h7E);       // refused, terminal 3 busy

    // Phase one: a sluggish sender against a receiver that stalls a lot.
    send_idle_pct = 26;
    recv_idle_pct = 55;
    random_events(340, 40, -1);

    // Phase two: roles swapped. One terminal is flooded until both of its
    // queues overflow and wrap, then worked back down with reads and
    // completions mixed with fresh typing.
    send_idle_pct = 55;
    recv_idle_pct = 26;
    flood_term = $urandom_range(0, TERMINALS - 1);
    flood_terminal(flood_term);
    random_events(90, 20, flood_term);

    // Phase three: back to back, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_events(330, 40, -1);

    // The last beat was taken at the edge just passed, so valid drops now.
    item_ch.valid <= 1'b0;
    @(posedge clk);

    // Drain: every predicted beat must come out, then a quiet wait catches
    // any stray beat the core might still emit.
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("** terminal_line_discipline_core: PASSED **");
    end else begin
      $display("** terminal_line_discipline_core: FAILED **");
    end
    $finish;
  end

endmodule
